// ===== sv/external_clock_timer_bank_assert.svh =====
// ----------------------------------------------------------------------------
// timer bank assertion macros
// shared assertion forms for the timer bank
// ----------------------------------------------------------------------------
`ifndef EXTERNAL_CLOCK_TIMER_BANK_ASSERT_SVH
`define EXTERNAL_CLOCK_TIMER_BANK_ASSERT_SVH

// implication checked on every edge outside reset
`define ECT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication
`define ECT_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ===== sv/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// ect_pkg
// types, constants and command structs of the timer bank
// ----------------------------------------------------------------------------
package ect_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam logic [62:0] TIME_MAX = {63{1'b1}};
    localparam logic [30:0] OVR_MAX = {31{1'b1}};

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_ARM   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] KIND_EXPIRY = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_CLOCK  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_DIV,
        S_RESCHED,
        S_OUT_EVT,
        S_OUT_CLK,
        S_OUT_STAT,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic set_clock;
        logic scan_clear;
        logic scan_step;
        logic div_start;
        logic fire;
        logic arm_write;
        logic out_evt;
        logic out_clk;
        logic out_stat;
    } t_cmd;

    typedef struct packed {
        logic       scan_last;
        logic       have_pick;
        logic       pick_periodic;
        logic       div_done;
        logic [1:0] action;
        logic       idx_valid;
        logic       pick_report;
    } t_sts;

endpackage

// ===== sv/ect_divider.sv =====
// ----------------------------------------------------------------------------
// ect_divider
// restoring divider, one quotient bit per cycle, 63-bit operands
// ----------------------------------------------------------------------------
module ect_divider
    import ect_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_num,
    input  logic [62:0] i_den,
    output logic        o_done,
    output logic [62:0] o_quo,
    output logic [62:0] o_rem
);

    logic [62:0] r_quo;
    logic [63:0] r_rem;
    logic [62:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_trial;
    logic [63:0] w_diff;

    assign w_trial = {r_rem[62:0], r_quo[62]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd62;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[63]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[61:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[61:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[62:0];

endmodule

// ===== sv/ect_datapath.sv =====
// ----------------------------------------------------------------------------
// ect_datapath
// timer registers, sequential earliest-expiry scan, rescheduling and result
// ----------------------------------------------------------------------------
module ect_datapath
    import ect_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [15:0] i_report_mask,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_timer_index,
    input  logic [62:0] i_time_value,
    input  logic [62:0] i_period_value,
    input  logic        i_absolute,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_timer_out,
    output logic [63:0] o_remaining_ns,
    output logic [62:0] o_period_out,
    output logic [30:0] o_overrun_out,
    output logic        o_is_last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [62:0] r_exp [NUM_TIMERS];
    logic [62:0] r_per [NUM_TIMERS];
    logic [30:0] r_ovr [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] r_done;
    logic [62:0] r_now;
    logic [63:0] r_step;

    logic [1:0]  r_act;
    logic [3:0]  r_idx;
    logic [62:0] r_tv;
    logic [62:0] r_pv;
    logic        r_abs;

    logic [IW-1:0] r_scan;
    logic          r_have;
    logic [IW-1:0] r_pick;
    logic [62:0]   r_pexp;

    logic [62:0] r_nx;
    logic [30:0] r_novr;

    logic        w_div_done;
    logic [62:0] w_quo;
    logic [62:0] w_rem;
    logic [62:0] w_late;
    logic        w_cand;
    logic        w_idx_ok;
    logic [IW-1:0] w_i;
    logic [63:0] w_rel;
    logic [62:0] w_ex;
    logic [63:0] w_nx;
    logic [62:0] w_pp;

    assign w_idx_ok = ({28'd0, r_idx} < 32'(NUM_TIMERS));
    assign w_i      = r_idx[IW-1:0];
    assign w_late   = r_now - r_pexp;
    assign w_pp     = r_per[r_pick];
    // next expiry = now + per - (late mod per)
    assign w_nx     = {1'b0, r_now} + {1'b0, w_pp} - {1'b0, w_rem};
    assign w_rel    = {1'b0, r_now} + {1'b0, r_tv};
    assign w_ex     = r_abs ? r_tv : (w_rel[63] ? TIME_MAX : w_rel[62:0]);
    assign w_cand   = r_armed[r_scan] && !r_done[r_scan] && (r_exp[r_scan] <= r_now)
                      && (!r_have || r_exp[r_scan] < r_pexp);

    ect_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_late),
        .i_den   (w_pp),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            r_done  <= '0;
            r_now   <= '0;
            r_step  <= '0;
            r_have  <= 1'b0;
            r_scan  <= '0;
            o_kind  <= KIND_CLOCK;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_exp[k] <= '0;
                r_per[k] <= '0;
                r_ovr[k] <= '0;
            end
        end else begin
            if (i_cmd.load_in) begin
                r_act <= i_action;
                r_idx <= i_timer_index;
                r_tv  <= i_time_value;
                r_pv  <= i_period_value;
                r_abs <= i_absolute;
            end
            if (i_cmd.set_clock) begin
                r_step <= {1'b0, r_tv} - {1'b0, r_now};
                r_now  <= r_tv;
                r_done <= '0;
            end
            if (i_cmd.scan_clear) begin
                r_scan <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (w_cand) begin
                    r_have <= 1'b1;
                    r_pick <= r_scan;
                    r_pexp <= r_exp[r_scan];
                end
                r_scan <= r_scan + IW'(1);
            end
            if (w_div_done) begin
                r_nx   <= w_nx[63] ? TIME_MAX : w_nx[62:0];
                r_novr <= (w_quo > {32'd0, OVR_MAX}) ? OVR_MAX : w_quo[30:0];
            end
            if (i_cmd.fire) begin
                r_done[r_pick] <= 1'b1;
                if (r_per[r_pick] != '0) begin
                    r_exp[r_pick] <= r_nx;
                    r_ovr[r_pick] <= r_novr;
                end else begin
                    r_exp[r_pick]   <= '0;
                    r_armed[r_pick] <= 1'b0;
                end
            end
            if (i_cmd.out_evt) begin
                o_kind         <= KIND_EXPIRY;
                o_timer_out    <= 4'(r_pick);
                o_remaining_ns <= (r_per[r_pick] != '0) ? {1'b0, r_nx - r_now} : '0;
                o_period_out   <= r_per[r_pick];
                o_overrun_out  <= (r_per[r_pick] != '0) ? r_novr : r_ovr[r_pick];
                o_is_last      <= 1'b0;
            end
            if (i_cmd.out_clk) begin
                o_kind         <= KIND_CLOCK;
                o_timer_out    <= '0;
                o_remaining_ns <= r_step;
                o_period_out   <= '0;
                o_overrun_out  <= '0;
                o_is_last      <= 1'b1;
            end
            if (i_cmd.out_stat) begin
                o_kind      <= KIND_STATUS;
                o_timer_out <= r_idx;
                o_is_last   <= 1'b1;
                if (!w_idx_ok) begin
                    o_remaining_ns <= '0;
                    o_period_out   <= '0;
                    o_overrun_out  <= '0;
                end else begin
                    o_remaining_ns <= r_armed[w_i] ?
                                      {1'b0, r_exp[w_i]} - {1'b0, r_now} : '0;
                    if (r_act == ACT_QUERY || r_armed[w_i]) begin
                        o_period_out  <= r_per[w_i];
                        o_overrun_out <= r_ovr[w_i];
                    end else begin
                        o_period_out  <= '0;
                        o_overrun_out <= '0;
                    end
                end
            end
            if (i_cmd.arm_write && w_idx_ok) begin
                r_exp[w_i]   <= (r_tv != '0) ? w_ex : '0;
                r_per[w_i]   <= (r_tv != '0) ? r_pv : '0;
                r_armed[w_i] <= (r_tv != '0);
                r_ovr[w_i]   <= '0;
            end
        end
    end

    always_comb begin
        o_sts.scan_last     = (r_scan == IW'(NUM_TIMERS - 1));
        o_sts.have_pick     = r_have;
        o_sts.pick_periodic = (r_per[r_pick] != '0);
        o_sts.div_done      = w_div_done;
        o_sts.action        = r_act;
        o_sts.idx_valid     = w_idx_ok;
        o_sts.pick_report   = (32'(r_pick) < 32'd16) && i_report_mask[4'(r_pick)];
    end

endmodule

// ===== sv/ect_ctrl.sv =====
// ----------------------------------------------------------------------------
// ect_ctrl
// sequencer for clock updates, arming and queries
// ----------------------------------------------------------------------------
module ect_ctrl
    import ect_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_state r_after, n_after;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                case (i_sts.action)
                    ACT_SET: begin
                        o_cmd.set_clock  = 1'b1;
                        o_cmd.scan_clear = 1'b1;
                        n_state = S_SCAN;
                    end
                    ACT_ARM, ACT_QUERY: begin
                        n_state = S_WAIT;
                        n_after = S_OUT_STAT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_RESCHED;
            end
            S_RESCHED: begin
                if (!i_sts.have_pick) begin
                    n_state = S_WAIT;
                    n_after = S_OUT_CLK;
                end else if (i_sts.pick_periodic) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT_EVT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT_EVT;
            end
            S_OUT_EVT: begin
                if (!i_sts.pick_report) begin
                    o_cmd.fire       = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state = S_SCAN;
                end else if (!r_ovalid || !i_stall) begin
                    o_cmd.out_evt    = 1'b1;
                    o_cmd.fire       = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_WAIT: begin
                if (!r_ovalid || !i_stall) n_state = r_after;
            end
            S_OUT_CLK: begin
                o_cmd.out_clk = 1'b1;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_OUT_STAT: begin
                o_cmd.out_stat  = 1'b1;
                o_cmd.arm_write = (i_sts.action == ACT_ARM);
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/external_clock_timer_bank.sv =====
// ----------------------------------------------------------------------------
// external_clock_timer_bank
// bank of one-shot and periodic timers on an externally set clock
// ----------------------------------------------------------------------------
// input channel i_valid/o_stall takes one command beat: set clock, arm or
// query. output channel o_valid/i_stall returns result beats, is_last on
// the final one. report_mask is written through i_cfg_we/i_cfg_data.
// arm and query: one status beat after acceptance.
// set clock: each firing costs a scan over the timer registers, and a
// pass through the serial divider for a periodic timer; with no firing
// the clock beat follows a single scan.
// one command is in work at a time; o_stall stays high until the last
// beat is in the output register.
// synchronous reset disarms all timers and zeroes clock and mask.
// a stalled output beat holds; the sequencer waits before the next beat.
// ----------------------------------------------------------------------------
module external_clock_timer_bank
    import ect_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_timer_index,
    input  logic [62:0] i_time_value,
    input  logic [62:0] i_period_value,
    input  logic        i_absolute,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_timer_out,
    output logic [63:0] o_remaining_ns,
    output logic [62:0] o_period_out,
    output logic [30:0] o_overrun_out,
    output logic        o_is_last
);

`include "external_clock_timer_bank_assert.svh"

    logic [15:0] r_mask;
    t_cmd        w_cmd;
    t_sts        w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data;
        end
    end

    ect_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ect_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_report_mask  (r_mask),
        .i_action       (i_action),
        .i_timer_index  (i_timer_index),
        .i_time_value   (i_time_value),
        .i_period_value (i_period_value),
        .i_absolute     (i_absolute),
        .o_kind         (o_kind),
        .o_timer_out    (o_timer_out),
        .o_remaining_ns (o_remaining_ns),
        .o_period_out   (o_period_out),
        .o_overrun_out  (o_overrun_out),
        .o_is_last      (o_is_last)
    );

    `ECT_ASSERT_IMP(a_no_accept_while_out_last, i_clk, i_rst_n,
        (!o_stall), (!o_valid || o_is_last))
    `ECT_ASSERT_NXT(a_stalled_beat_holds, i_clk, i_rst_n,
        (o_valid && i_stall), (o_valid && $stable(o_remaining_ns)))
    `ECT_ASSERT_IMP(a_clock_beat_last, i_clk, i_rst_n,
        (o_valid && o_kind == KIND_CLOCK), (o_is_last))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer bank testbench
// drives clock updates, arm, query and unused-action commands through the command channel
// with random gaps and output stalls, predicts every result beat from a
// behavioral copy of the timer bank and compares beats field by field
// ----------------------------------------------------------------------------
module testbench;
    import ect_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int N_TMR = 16;
    localparam int CFG_SETTLE = 40;

    typedef struct {
        bit          is_cfg;
        logic [15:0] mask;
        logic [1:0]  action;
        logic [3:0]  idx;
        logic [62:0] tv;
        logic [62:0] pv;
        logic        absf;
    } t_cmd_item;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  tmr;
        logic [63:0] rem;
        logic [62:0] per;
        logic [30:0] ovr;
        logic        last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [3:0]  i_timer_index;
    logic [62:0] i_time_value;
    logic [62:0] i_period_value;
    logic        i_absolute;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [3:0]  o_timer_out;
    logic [63:0] o_remaining_ns;
    logic [62:0] o_period_out;
    logic [30:0] o_overrun_out;
    logic        o_is_last;

    external_clock_timer_bank u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_timer_index(i_timer_index),
        .i_time_value(i_time_value), .i_period_value(i_period_value),
        .i_absolute(i_absolute),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_timer_out(o_timer_out),
        .o_remaining_ns(o_remaining_ns), .o_period_out(o_period_out),
        .o_overrun_out(o_overrun_out), .o_is_last(o_is_last)
    );

    t_cmd_item   pending_cmds[$];
    t_beat       expected_beats[$];
    int          mismatches = 0;
    bit          stim_done = 0;

    // behavioral timer state
    logic [15:0] mdl_mask;
    logic [62:0] mdl_now;
    logic [62:0] mdl_expiry[N_TMR];
    logic [62:0] mdl_period[N_TMR];
    bit          mdl_armed[N_TMR];
    logic [30:0] mdl_ovr[N_TMR];

    function automatic void push_beat(logic [1:0] k, logic [3:0] t, logic [63:0] r,
                                      logic [62:0] p, logic [30:0] o, logic l);
        t_beat b;
        b.kind = k; b.tmr = t; b.rem = r; b.per = p; b.ovr = o; b.last = l;
        expected_beats.push_back(b);
    endfunction

    function automatic logic [63:0] remaining_of(int i);
        logic [63:0] r;
        r = mdl_armed[i] ? ({1'b0, mdl_expiry[i]} - {1'b0, mdl_now}) : 64'd0;
        return r;
    endfunction

    function automatic void advance_clock(logic [62:0] t);
        bit          fired[N_TMR];
        logic [63:0] step_ns, late, ovr, nx, rem, prd;
        int          pick;
        step_ns = {1'b0, t} - {1'b0, mdl_now};
        mdl_now = t;
        foreach (fired[i]) fired[i] = 0;
        forever begin
            pick = -1;
            for (int i = 0; i < N_TMR; i++) begin
                if (!mdl_armed[i] || fired[i] || mdl_expiry[i] > t) continue;
                if (pick < 0 || mdl_expiry[i] < mdl_expiry[pick]) pick = i;
            end
            if (pick < 0) break;
            fired[pick] = 1;
            prd = {1'b0, mdl_period[pick]};
            rem = 0;
            if (prd != 0) begin
                late = {1'b0, t} - {1'b0, mdl_expiry[pick]};
                ovr = late / prd;
                nx = {1'b0, t} + ((ovr + 64'd1) * prd - late);
                if (nx > {1'b0, TIME_MAX}) nx = {1'b0, TIME_MAX};
                mdl_expiry[pick] = nx[62:0];
                mdl_ovr[pick] = (ovr > {33'd0, OVR_MAX}) ? OVR_MAX : ovr[30:0];
                rem = nx - {1'b0, t};
            end else begin
                mdl_expiry[pick] = 0;
                mdl_armed[pick] = 0;
            end
            if (mdl_mask[pick])
                push_beat(KIND_EXPIRY, pick[3:0], rem, prd[62:0], mdl_ovr[pick], 1'b0);
        end
        push_beat(KIND_CLOCK, 4'd0, step_ns, 63'd0, 31'd0, 1'b1);
    endfunction

    function automatic void predict_command(t_cmd_item c);
        int          i;
        logic [63:0] ex;
        i = c.idx;
        case (c.action)
            ACT_SET: advance_clock(c.tv);
            ACT_QUERY: push_beat(KIND_STATUS, c.idx, remaining_of(i), mdl_period[i],
                                 mdl_ovr[i], 1'b1);
            ACT_ARM: begin
                push_beat(KIND_STATUS, c.idx, remaining_of(i),
                          mdl_armed[i] ? mdl_period[i] : 63'd0,
                          mdl_armed[i] ? mdl_ovr[i] : 31'd0, 1'b1);
                ex = {1'b0, c.tv};
                if (c.tv != 0 && !c.absf) begin
                    ex = {1'b0, mdl_now} + {1'b0, c.tv};
                    if (ex > {1'b0, TIME_MAX}) ex = {1'b0, TIME_MAX};
                end
                mdl_armed[i] = (c.tv != 0);
                mdl_expiry[i] = (c.tv != 0) ? ex[62:0] : 63'd0;
                mdl_period[i] = (c.tv != 0) ? c.pv : 63'd0;
                mdl_ovr[i] = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_wait(bit busy_phase);
        return busy_phase ? 0 : $urandom_range(0, 12);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // command driver
    int  cmd_gap;
    int  settle;
    bit  cmd_burst;
    t_cmd_item cur_cmd;

    always @(posedge i_clk) begin
        logic nv;
        logic we;
        if (!i_rst_n) begin
            i_valid <= 0;
            i_cfg_we <= 0;
            cmd_gap = 0;
            settle = 0;
            cmd_burst = 0;
        end else begin
            nv = i_valid;
            we = 0;
            if (i_valid && !o_stall) begin
                predict_command(cur_cmd);
                nv = 0;
                if ($urandom_range(0, 15) == 0) cmd_burst = !cmd_burst;
                cmd_gap = draw_wait(cmd_burst);
            end
            if (i_valid || expected_beats.size() != 0) settle = 0;
            else if (settle < CFG_SETTLE) settle++;
            if (!nv) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                end else if (pending_cmds.size() != 0) begin
                    if (pending_cmds[0].is_cfg) begin
                        if (settle >= CFG_SETTLE && !i_valid) begin
                            we = 1;
                            i_cfg_data <= pending_cmds[0].mask;
                            mdl_mask = pending_cmds[0].mask;
                            void'(pending_cmds.pop_front());
                        end
                    end else begin
                        cur_cmd = pending_cmds.pop_front();
                        i_action <= cur_cmd.action;
                        i_timer_index <= cur_cmd.idx;
                        i_time_value <= cur_cmd.tv;
                        i_period_value <= cur_cmd.pv;
                        i_absolute <= cur_cmd.absf;
                        nv = 1;
                    end
                end else begin
                    stim_done = 1;
                end
            end
            i_valid <= nv;
            i_cfg_we <= we;
        end
    end

    // result monitor
    int  out_wait;
    bit  out_burst;

    always @(posedge i_clk) begin
        t_beat e;
        if (!i_rst_n) begin
            i_stall <= 0;
            out_wait = 0;
            out_burst = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat kind=%0d timer=%0d", o_kind, o_timer_out);
                end else begin
                    e = expected_beats.pop_front();
                    if (o_kind !== e.kind || o_timer_out !== e.tmr
                            || o_remaining_ns !== e.rem || o_period_out !== e.per
                            || o_overrun_out !== e.ovr || o_is_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("beat mismatch exp kind=%0d tmr=%0d rem=%0d per=%0d ovr=%0d last=%0d",
                                     e.kind, e.tmr, $signed(e.rem), e.per, e.ovr, e.last);
                            $display("  got kind=%0d tmr=%0d rem=%0d per=%0d ovr=%0d last=%0d",
                                     o_kind, o_timer_out, $signed(o_remaining_ns),
                                     o_period_out, o_overrun_out, o_is_last);
                        end
                    end
                end
                if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
                out_wait = draw_wait(out_burst);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
            end
        end
    end

    // stimulus
    logic [62:0] gen_now;

    function automatic logic [62:0] rand_time();
        return 63'({$urandom, $urandom} & {1'b0, TIME_MAX});
    endfunction

    function automatic void add_cmd(logic [1:0] a, logic [3:0] idx, logic [62:0] tv,
                                    logic [62:0] pv, logic absf);
        t_cmd_item c;
        c.is_cfg = 0; c.mask = 0;
        c.action = a; c.idx = idx; c.tv = tv; c.pv = pv; c.absf = absf;
        pending_cmds.push_back(c);
        if (a == ACT_SET) gen_now = tv;
    endfunction

    function automatic void add_mask(logic [15:0] m);
        t_cmd_item c;
        c.is_cfg = 1; c.mask = m;
        c.action = ACT_UNUSED; c.idx = 0; c.tv = 0; c.pv = 0; c.absf = 0;
        pending_cmds.push_back(c);
    endfunction

    initial begin
        int r;
        logic [62:0] tv, pv;
        i_rst_n = 0;
        i_valid = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_stall = 0;
        i_action = 0;
        i_timer_index = 0;
        i_time_value = 0;
        i_period_value = 0;
        i_absolute = 0;
        mdl_mask = 0;
        mdl_now = 0;
        for (int i = 0; i < N_TMR; i++) begin
            mdl_expiry[i] = 0; mdl_period[i] = 0; mdl_armed[i] = 0; mdl_ovr[i] = 0;
        end
        gen_now = 0;

        // directed part
        add_mask(16'hFFFF);
        add_cmd(ACT_QUERY, 0, 0, 0, 0);
        add_cmd(ACT_ARM, 0, 100, 0, 0);
        add_cmd(ACT_ARM, 1, 100, 0, 1);
        add_cmd(ACT_ARM, 2, 50, 1, 1);
        add_cmd(ACT_ARM, 3, TIME_MAX, 7, 0);
        add_cmd(ACT_ARM, 6, 100, 30, 1);
        add_cmd(ACT_SET, 0, 63'd1 << 40, 0, 0);
        add_cmd(ACT_QUERY, 2, 0, 0, 0);
        add_cmd(ACT_ARM, 4, 10, 0, 1);
        add_cmd(ACT_QUERY, 4, 0, 0, 0);
        add_cmd(ACT_SET, 0, 5, 0, 0);
        add_cmd(ACT_SET, 0, TIME_MAX, 0, 0);
        add_cmd(ACT_ARM, 3, 0, 0, 0);
        add_cmd(ACT_UNUSED, 15, TIME_MAX, TIME_MAX, 1);
        add_cmd(ACT_ARM, 5, TIME_MAX, TIME_MAX, 1);
        add_cmd(ACT_ARM, 15, 1, TIME_MAX, 0);
        add_cmd(ACT_QUERY, 15, 0, 0, 0);
        add_cmd(ACT_SET, 0, 0, 0, 0);
        add_mask(16'h0000);
        add_cmd(ACT_SET, 0, 63'd1 << 50, 0, 0);

        // random part: arm near the current time, then step the clock across
        for (int n = 0; n < 320; n++) begin
            if (n % 80 == 40) add_mask(16'($urandom));
            if (n % 80 == 0) add_mask(16'hFFFF);
            r = $urandom_range(0, 99);
            if (r < 4) begin
                add_cmd(2'($urandom_range(0, 3)), 4'($urandom), rand_time(), rand_time(),
                        1'($urandom_range(0, 1)));
            end else if (r < 30) begin
                tv = (r < 8) ? rand_time() : (($urandom_range(0, 9) == 0)
                     ? gen_now - $urandom_range(0, 3000) : gen_now + $urandom_range(0, 8000));
                add_cmd(ACT_SET, 4'($urandom), tv, 0, 0);
            end else if (r < 80) begin
                pv = ($urandom_range(0, 2) == 0) ? 63'd0 : 63'($urandom_range(1, 2500));
                if ($urandom_range(0, 1)) begin
                    tv = ($urandom_range(0, 15) == 0) ? 63'd0 : 63'($urandom_range(1, 6000));
                    add_cmd(ACT_ARM, 4'($urandom), tv, pv, 0);
                end else begin
                    tv = gen_now + $urandom_range(0, 6000) - 1000;
                    add_cmd(ACT_ARM, 4'($urandom), tv, pv, 1);
                end
            end else begin
                add_cmd(ACT_QUERY, 4'($urandom), rand_time(), rand_time(),
                        1'($urandom_range(0, 1)));
            end
        end
        add_mask(16'h0000);
        add_cmd(ACT_SET, 0, TIME_MAX, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        wait (stim_done && expected_beats.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
